[rtl/scar_pkg.sv]
// ----------------------------------------------------------------------------
// Stereo comb/allpass reverb package
// Shared sizes, delay line layout, register indexes and saturation helper.
// ----------------------------------------------------------------------------
package scar_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int COMB_COUNT    = 4;
	localparam int ALLPASS_COUNT = 2;

	// Delay lengths, in samples.
	localparam logic [10:0] COMB_LEN [COMB_COUNT] = '{11'd1116, 11'd1188, 11'd1277, 11'd1356};
	localparam logic [9:0]  AP_LEN   [ALLPASS_COUNT] = '{10'd556, 10'd441};

	// One channel's comb lines are packed back to back; the second channel follows.
	localparam int COMB_STRIDE = 4937;
	localparam int AP_STRIDE   = 997;
	localparam int COMB_DEPTH  = 2 * COMB_STRIDE;
	localparam int AP_DEPTH    = 2 * AP_STRIDE;
	localparam int COMB_AW     = $clog2(COMB_DEPTH);
	localparam int AP_AW       = $clog2(AP_DEPTH);

	localparam logic [COMB_AW-1:0] COMB_BASE [COMB_COUNT] =
		'{14'd0, 14'd1116, 14'd2304, 14'd3581};
	localparam logic [AP_AW-1:0] AP_BASE [ALLPASS_COUNT] = '{11'd0, 11'd556};

	localparam int CIDX_W = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
	localparam int AIDX_W = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;

	// 0.9 in Q0.16.
	localparam logic [17:0] GAIN_09 = 18'd58982;

	// Operand and product widths of the shared multiply-add unit.
	localparam int OP_W   = 18;
	localparam int PROD_W = 36;

	typedef enum logic [2:0] {
		REG_ROOM_SIZE     = 3'd0,
		REG_WET_MIX       = 3'd1,
		REG_INPUT_SELECT  = 3'd2,
		REG_OUTPUT_SELECT = 3'd3,
		REG_CHANNEL_COUNT = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		SEL_LEFT  = 2'd0,
		SEL_RIGHT = 2'd1,
		SEL_BOTH  = 2'd2,
		SEL_NONE  = 2'd3
	} chan_sel_t;

	// Request to the multiply-add unit.
	typedef struct packed {
		logic                     en;
		logic                     acc;
		logic signed [OP_W-1:0]   a;
		logic signed [OP_W-1:0]   b;
		logic signed [PROD_W-1:0] add;
	} mac_req_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
		lo = -hi - PROD_W'(1);
		if (v > hi)
			return hi[SAMPLE_BITS-1:0];
		else if (v < lo)
			return lo[SAMPLE_BITS-1:0];
		return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

[rtl/scar_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scar_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[rtl/scar_mac.sv]
// ----------------------------------------------------------------------------
// Shared multiply-add unit
// Registered a * b plus either a given addend or the previous result.
// ----------------------------------------------------------------------------
module scar_mac import scar_pkg::*; (
	input  logic                     clk,
	input  mac_req_t                 req,
	output logic signed [PROD_W-1:0] p_q
);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] addend;

	assign prod   = req.a * req.b;
	assign addend = req.acc ? p_q : req.add;

	always_ff @(posedge clk) begin
		if (req.en)
			p_q <= prod + addend;
	end

endmodule

[rtl/stereo_comb_allpass_reverb_core.sv]
// ----------------------------------------------------------------------------
// Stereo comb/allpass reverb core
// Four parallel feedback combs and two series allpass stages per channel,
// then a wet/dry mix, all run by a sequencer around one multiply-add unit.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------
//  in        in_valid / in_stall  left_in, right_in
//  out       out_valid / out_stall left_out, right_out, left_written,
//                                  right_written
//  cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// After reset the delay memories are cleared one entry per cycle, with
// in_stall held high meanwhile. Configuration writes are taken at any time
// (cfg_ready is always high).
// A request runs from acceptance to the result register through the gain
// setup (S_GAIN, S_GAIN_W), then per channel reverberated each comb tap as a
// memory read, a multiply and a write-back, and each allpass tap as a read
// and a write, then the wet/dry mix (S_MIXA, S_MIXB, S_MIXW) for each side
// and the hand-off to the output (S_DONE).
// The block takes one request at a time. A finished result waits in the
// output register while the next request is accepted and processed; the
// sequencer only holds at its last step if that register is still full.
// ----------------------------------------------------------------------------
module stereo_comb_allpass_reverb_core import scar_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          left_written,
	output logic                          right_written,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [15:0]                   cfg_data
);

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_GAIN   = 13'b0000000000100,
		S_GAIN_W = 13'b0000000001000,
		S_CRD    = 13'b0000000010000,
		S_CDAT   = 13'b0000000100000,
		S_CWR    = 13'b0000001000000,
		S_ARD    = 13'b0000010000000,
		S_ADAT   = 13'b0000100000000,
		S_MIXA   = 13'b0001000000000,
		S_MIXB   = 13'b0010000000000,
		S_MIXW   = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] room_size_q;
	logic [15:0] wet_mix_q;
	logic [1:0]  input_select_q;
	logic [1:0]  output_select_q;
	logic [1:0]  channel_count_q;

	// Per-request working registers.
	logic signed [SAMPLE_BITS-1:0] dry_q [2];
	logic signed [17:0]            wet_q [2];
	logic signed [SAMPLE_BITS-1:0] res_q [2];
	logic [15:0]                   gain_q;
	logic                          two_ch_q;
	logic                          ch_q;
	logic [CIDX_W-1:0]             c_q;
	logic [AIDX_W-1:0]             a_q;
	logic signed [17:0]            sum_q;
	logic signed [17:0]            x_q;
	logic [COMB_AW-1:0]            clr_q;

	// Delay positions, shared by both channels.
	logic [10:0] cpos_q [COMB_COUNT];
	logic [9:0]  apos_q [ALLPASS_COUNT];

	// Output register.
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] left_out_q;
	logic signed [SAMPLE_BITS-1:0] right_out_q;
	logic                          left_written_q;
	logic                          right_written_q;

	// Memory and multiply-add hookup.
	logic                          comb_we;
	logic [COMB_AW-1:0]            comb_waddr;
	logic [SAMPLE_BITS-1:0]        comb_wdata;
	logic [COMB_AW-1:0]            comb_addr;
	logic [SAMPLE_BITS-1:0]        comb_rdata;
	logic                          ap_we;
	logic [AP_AW-1:0]              ap_waddr;
	logic [SAMPLE_BITS-1:0]        ap_wdata;
	logic [AP_AW-1:0]              ap_addr;
	logic [SAMPLE_BITS-1:0]        ap_rdata;
	mac_req_t                      mac_req;
	logic signed [PROD_W-1:0]      mac_p;

	logic signed [17:0]            y_s;
	logic signed [17:0]            b_s;
	logic signed [17:0]            half_x;
	logic signed [17:0]            half_b;
	logic signed [PROD_W-1:0]      comb_new;
	logic signed [PROD_W-1:0]      ap_new;
	logic signed [17:0]            x_next;
	logic                          out_free;
	logic                          wl;
	logic                          wr;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// The current tap's address follows the channel, tap index and position.
	assign comb_addr = (ch_q ? COMB_AW'(COMB_STRIDE) : '0) + COMB_BASE[c_q]
		+ COMB_AW'(cpos_q[c_q]);
	assign ap_addr = (ch_q ? AP_AW'(AP_STRIDE) : '0) + AP_BASE[a_q] + AP_AW'(apos_q[a_q]);

	assign y_s    = 18'(signed'(comb_rdata));
	assign b_s    = 18'(signed'(ap_rdata));
	assign half_x = (x_q + 18'sd1) >>> 1;
	assign half_b = (b_s + 18'sd1) >>> 1;
	assign x_next = b_s - half_x;

	// Comb write-back: dry sample plus the rounded feedback product.
	assign comb_new = PROD_W'(dry_q[ch_q]) + (mac_p >>> 16);
	assign ap_new   = PROD_W'(x_q) + PROD_W'(half_b);

	assign comb_we    = (state_q == S_CLEAR) || (state_q == S_CWR);
	assign comb_waddr = (state_q == S_CLEAR) ? clr_q : comb_addr;
	assign comb_wdata = (state_q == S_CLEAR) ? '0 : sat_s(comb_new);
	assign ap_we      = ((state_q == S_CLEAR) && (clr_q < COMB_AW'(AP_DEPTH)))
		|| (state_q == S_ADAT);
	assign ap_waddr   = (state_q == S_CLEAR) ? clr_q[AP_AW-1:0] : ap_addr;
	assign ap_wdata   = (state_q == S_CLEAR) ? '0 : sat_s(ap_new);

	assign wl = (output_select_q == SEL_LEFT) || (output_select_q == SEL_BOTH);
	assign wr = (output_select_q == SEL_RIGHT) || (output_select_q == SEL_BOTH);

	// Operand selection for the multiply-add unit.
	always_comb begin
		mac_req     = '0;
		mac_req.add = PROD_W'(32768);
		unique case (state_q)
			S_GAIN: begin
				mac_req.en = 1'b1;
				mac_req.a  = OP_W'(room_size_q);
				mac_req.b  = GAIN_09;
			end
			S_CDAT: begin
				mac_req.en = 1'b1;
				mac_req.a  = y_s;
				mac_req.b  = OP_W'(gain_q);
			end
			S_MIXA: begin
				mac_req.en = 1'b1;
				mac_req.a  = wet_q[ch_q];
				mac_req.b  = OP_W'(wet_mix_q);
			end
			S_MIXB: begin
				mac_req.en  = 1'b1;
				mac_req.acc = 1'b1;
				mac_req.a   = OP_W'(dry_q[ch_q]);
				mac_req.b   = OP_W'(18'd65536) - OP_W'(wet_mix_q);
			end
			default: begin
				mac_req.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_size_q     <= 16'd32768;
			wet_mix_q       <= 16'd32768;
			input_select_q  <= SEL_BOTH;
			output_select_q <= SEL_BOTH;
			channel_count_q <= 2'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROOM_SIZE:     room_size_q     <= cfg_data;
				REG_WET_MIX:       wet_mix_q       <= cfg_data;
				REG_INPUT_SELECT:  input_select_q  <= cfg_data[1:0];
				REG_OUTPUT_SELECT: output_select_q <= cfg_data[1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			ch_q        <= 1'b0;
			c_q         <= '0;
			a_q         <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < COMB_COUNT; i++)
				cpos_q[i] <= '0;
			for (int i = 0; i < ALLPASS_COUNT; i++)
				apos_q[i] <= '0;
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if ((state_q == S_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == COMB_AW'(COMB_DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_GAIN;
						ch_q    <= 1'b0;
						c_q     <= '0;
						a_q     <= '0;
					end
				end
				S_GAIN:   state_q <= S_GAIN_W;
				S_GAIN_W: state_q <= S_CRD;
				S_CRD:    state_q <= S_CDAT;
				S_CDAT:   state_q <= S_CWR;
				S_CWR: begin
					if (c_q == CIDX_W'(COMB_COUNT - 1)) begin
						c_q     <= '0;
						state_q <= S_ARD;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_CRD;
					end
				end
				S_ARD: state_q <= S_ADAT;
				S_ADAT: begin
					if (a_q == AIDX_W'(ALLPASS_COUNT - 1)) begin
						a_q <= '0;
						if (ch_q || !two_ch_q) begin
							ch_q    <= 1'b0;
							state_q <= S_MIXA;
						end else begin
							ch_q    <= 1'b1;
							state_q <= S_CRD;
						end
					end else begin
						a_q     <= a_q + 1'b1;
						state_q <= S_ARD;
					end
				end
				S_MIXA: state_q <= S_MIXB;
				S_MIXB: state_q <= S_MIXW;
				S_MIXW: begin
					if (ch_q) begin
						ch_q    <= 1'b0;
						state_q <= S_DONE;
					end else begin
						ch_q    <= 1'b1;
						state_q <= S_MIXA;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q     <= S_IDLE;
						for (int i = 0; i < COMB_COUNT; i++)
							cpos_q[i] <= (cpos_q[i] == COMB_LEN[i] - 11'd1) ? '0
								: cpos_q[i] + 11'd1;
						for (int i = 0; i < ALLPASS_COUNT; i++)
							apos_q[i] <= (apos_q[i] == AP_LEN[i] - 10'd1) ? '0
								: apos_q[i] + 10'd1;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				wet_q[0] <= '0;
				wet_q[1] <= '0;
				two_ch_q <= (channel_count_q >= 2'd2);
				case (input_select_q)
					SEL_LEFT: begin
						dry_q[0] <= left_in;
						dry_q[1] <= left_in;
					end
					SEL_RIGHT: begin
						dry_q[0] <= right_in;
						dry_q[1] <= right_in;
					end
					SEL_BOTH: begin
						dry_q[0] <= left_in;
						dry_q[1] <= right_in;
					end
					default: begin
						dry_q[0] <= '0;
						dry_q[1] <= '0;
					end
				endcase
			end
			S_GAIN_W: begin
				gain_q <= mac_p[31:16];
				sum_q  <= '0;
			end
			S_CDAT: sum_q <= sum_q + y_s;
			S_CWR: begin
				if (c_q == CIDX_W'(COMB_COUNT - 1))
					x_q <= sum_q;
			end
			S_ADAT: begin
				x_q <= x_next;
				if (a_q == AIDX_W'(ALLPASS_COUNT - 1)) begin
					wet_q[ch_q] <= x_next;
					sum_q       <= '0;
				end
			end
			S_MIXW: res_q[ch_q] <= sat_s(mac_p >>> 16);
			S_DONE: begin
				if (out_free) begin
					left_out_q      <= wl ? res_q[0] : '0;
					right_out_q     <= wr ? res_q[1] : '0;
					left_written_q  <= wl;
					right_written_q <= wr;
				end
			end
			default: ;
		endcase
	end

	scar_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(COMB_DEPTH)) u_comb_ram (
		.clk   (clk),
		.we    (comb_we),
		.waddr (comb_waddr),
		.wdata (comb_wdata),
		.raddr (comb_addr),
		.rdata (comb_rdata)
	);

	scar_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(AP_DEPTH)) u_ap_ram (
		.clk   (clk),
		.we    (ap_we),
		.waddr (ap_waddr),
		.wdata (ap_wdata),
		.raddr (ap_addr),
		.rdata (ap_rdata)
	);

	scar_mac u_mac (
		.clk (clk),
		.req (mac_req),
		.p_q (mac_p)
	);

	assign out_valid     = out_valid_q;
	assign left_out      = left_out_q;
	assign right_out     = right_out_q;
	assign left_written  = left_written_q;
	assign right_written = right_written_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reverb core testbench
// Drives stereo sample requests through the comb/allpass reverb core under
// random idling on both sides, predicts every result with a behavioral model
// of the delay network, and compares each field of each result in order.
// ----------------------------------------------------------------------------
module tb;
	import scar_pkg::*;

	// Lengths and offsets of the predictor's own delay memories.
	localparam int CL0 = 1116, CL1 = 1188, CL2 = 1277, CL3 = 1356;
	localparam int AL0 = 556, AL1 = 441;
	localparam int COMB_SPAN = CL0 + CL1 + CL2 + CL3;
	localparam int AP_SPAN   = AL0 + AL1;
	localparam int NUM_RANDOM = 1100;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [15:0] left_s;
		logic signed [15:0] right_s;
		logic               lw;
		logic               rw;
	} mix_result_t;

	// One directed row: an optional register write, then a request.
	// If has_exp is set the typed-in result is also checked against the predictor's.
	typedef struct {
		bit                 do_cfg;
		reg_index_t         cfg_reg;
		logic [15:0]        cfg_val;
		logic signed [15:0] l;
		logic signed [15:0] r;
		bit                 has_exp;
		mix_result_t        exp;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] left_in;
	logic signed [15:0] right_in;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic left_written;
	logic right_written;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	stereo_comb_allpass_reverb_core dut (.*);

	// Predictor state: its own copy of the registers and delay memories.
	logic [15:0] room_q, wet_q;
	logic [1:0]  insel_q, outsel_q, chans_q;
	longint comb_mem [2*COMB_SPAN];
	longint ap_mem   [2*AP_SPAN];
	int     comb_pos [4];
	int     ap_pos   [2];

	mix_result_t pending_results[$];
	int     fail_count;
	longint cycle_count;
	bit     no_idle;       // last part of the run: no gaps either side
	bit     long_hold;     // receiver holds off for a long stretch
	bit     hold_pending;  // ask the receiver process to start a long hold

	function automatic longint round16(longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	task automatic reset_reverb_model();
		room_q = 16'd32768; wet_q = 16'd32768;
		insel_q = SEL_BOTH; outsel_q = SEL_BOTH; chans_q = 2'd2;
		foreach (comb_mem[i]) comb_mem[i] = 0;
		foreach (ap_mem[i]) ap_mem[i] = 0;
		foreach (comb_pos[i]) comb_pos[i] = 0;
		foreach (ap_pos[i]) ap_pos[i] = 0;
	endtask

	task automatic apply_register(reg_index_t idx, logic [15:0] val);
		case (idx)
			REG_ROOM_SIZE:     room_q = val;
			REG_WET_MIX:       wet_q = val;
			REG_INPUT_SELECT:  insel_q = val[1:0];
			REG_OUTPUT_SELECT: outsel_q = val[1:0];
			REG_CHANNEL_COUNT: chans_q = val[1:0];
			default: ;
		endcase
	endtask

	function automatic mix_result_t reverb_sample(logic signed [15:0] l, logic signed [15:0] r);
		int comb_len_t [4];
		int comb_off [4];
		int ap_len_t [2];
		int ap_off [2];
		longint dry [2];
		longint wet [2];
		longint g, df, y, b, x, sum;
		int active, a;
		mix_result_t res;
		comb_len_t = '{CL0, CL1, CL2, CL3};
		comb_off = '{0, CL0, CL0 + CL1, CL0 + CL1 + CL2};
		ap_len_t = '{AL0, AL1};
		ap_off = '{0, AL0};
		dry = '{0, 0};
		wet = '{0, 0};
		g = round16(longint'(room_q) * 58982);
		df = 65536 - longint'(wet_q);
		active = (chans_q == 0) ? 1 : ((chans_q > 2) ? 2 : chans_q);
		case (chan_sel_t'(insel_q))
			SEL_LEFT:  dry = '{l, l};
			SEL_RIGHT: dry = '{r, r};
			SEL_BOTH:  dry = '{l, r};
			default:   dry = '{0, 0};
		endcase
		for (int ch = 0; ch < active; ch++) begin
			sum = 0;
			for (int c = 0; c < 4; c++) begin
				a = ch * COMB_SPAN + comb_off[c] + comb_pos[c];
				y = comb_mem[a];
				comb_mem[a] = clip16(dry[ch] + round16(y * g));
				sum += y;
			end
			x = sum;
			for (int c = 0; c < 2; c++) begin
				a = ch * AP_SPAN + ap_off[c] + ap_pos[c];
				b = ap_mem[a];
				ap_mem[a] = clip16(x + ((b + 1) >>> 1));
				x = b - ((x + 1) >>> 1);
			end
			wet[ch] = x;
		end
		for (int c = 0; c < 4; c++)
			comb_pos[c] = (comb_pos[c] + 1 >= comb_len_t[c]) ? 0 : comb_pos[c] + 1;
		for (int c = 0; c < 2; c++)
			ap_pos[c] = (ap_pos[c] + 1 >= ap_len_t[c]) ? 0 : ap_pos[c] + 1;
		res.lw = (outsel_q == SEL_LEFT) || (outsel_q == SEL_BOTH);
		res.rw = (outsel_q == SEL_RIGHT) || (outsel_q == SEL_BOTH);
		res.left_s = res.lw ? 16'(clip16(round16(wet[0] * wet_q + dry[0] * df))) : 16'sd0;
		res.right_s = res.rw ? 16'(clip16(round16(wet[1] * wet_q + dry[1] * df))) : 16'sd0;
		return res;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter with a watchdog; the memory clear after reset is covered.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold on request so that the
	// block fills up and holds its input off while the sender keeps offering.
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				long_hold = 1'b1;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 6);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Result checker: sampled at the edge, compared with the oldest expectation.
	always @(posedge clk) begin
		mix_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (left_out !== want.left_s) begin
					$error("left_out expected %0d got %0d", want.left_s, left_out);
					fail_count++;
				end
				if (right_out !== want.right_s) begin
					$error("right_out expected %0d got %0d", want.right_s, right_out);
					fail_count++;
				end
				if (left_written !== want.lw) begin
					$error("left_written expected %0b got %0b", want.lw, left_written);
					fail_count++;
				end
				if (right_written !== want.rw) begin
					$error("right_written expected %0b got %0b", want.rw, right_written);
					fail_count++;
				end
			end
		end
	end

	// Register write through the configuration channel; only called while idle.
	// The caller drops cfg_valid after the last write of a group.
	task automatic write_register(reg_index_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, val);
	endtask

	// Stop offering, wait until every expected result has arrived, then let
	// the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Offer one request and hold it until taken. The expectation is queued at
	// the accepting edge, before the result can possibly appear. Valid stays
	// high afterwards so that back-to-back requests need no second assignment.
	task automatic send_sample(logic signed [15:0] l, logic signed [15:0] r);
		int n;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		do @(posedge clk); while (in_stall);
		pending_results.insert(pending_results.size(), reverb_sample(l, r));
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 255)) - 16'sd128;
			default: return 16'($urandom);
		endcase
	endfunction

	row_t rows [$];

	task automatic add_row(bit dc, reg_index_t ri, logic [15:0] rv,
			logic signed [15:0] l, logic signed [15:0] r,
			bit he, logic signed [15:0] el, logic signed [15:0] er, logic ew, logic rw);
		row_t t;
		t.do_cfg = dc; t.cfg_reg = ri; t.cfg_val = rv; t.l = l; t.r = r;
		t.has_exp = he; t.exp = '{el, er, ew, rw};
		rows.insert(rows.size(), t);
	endtask

	initial begin
		mix_result_t model_res;
		reg_index_t ri;
		fail_count = 0;
		no_idle = 1'b0;
		long_hold = 1'b0;
		hold_pending = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		left_in = '0;
		right_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROOM_SIZE;
		cfg_data = '0;
		reset_reverb_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows. With empty delay lines the wet path is zero, so the
		// first outputs are half the dry sample at the reset mix.
		add_row(0, REG_ROOM_SIZE, 0, 16'sh7FFF, 16'sh8000, 1, 16'sd16384, -16'sd16384, 1, 1);
		add_row(0, REG_ROOM_SIZE, 0, 16'sd0, 16'sd0, 1, 16'sd0, 16'sd0, 1, 1);
		// Fully dry mix passes the input straight through.
		add_row(1, REG_WET_MIX, 16'd0, 16'sh8000, 16'sh7FFF, 1, 16'sh8000, 16'sh7FFF, 1, 1);
		add_row(1, REG_ROOM_SIZE, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0, 0);
		add_row(1, REG_WET_MIX, 16'hFFFF, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0, 0);
		add_row(1, REG_INPUT_SELECT, SEL_LEFT, 16'sd1234, -16'sd999, 0, 0, 0, 0, 0);
		add_row(1, REG_INPUT_SELECT, SEL_RIGHT, 16'sd1234, -16'sd999, 0, 0, 0, 0, 0);
		// Input select of three takes both dry samples as zero.
		add_row(1, REG_INPUT_SELECT, SEL_NONE, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0, 0);
		add_row(1, REG_INPUT_SELECT, SEL_BOTH, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0);
		// An unwritten side reads zero with its flag low.
		add_row(1, REG_OUTPUT_SELECT, SEL_LEFT, 16'sd500, 16'sd500, 1, 16'sd0, 16'sd0, 1, 0);
		add_row(1, REG_OUTPUT_SELECT, SEL_RIGHT, 16'sd500, 16'sd500, 1, 16'sd0, 16'sd0, 0, 1);
		add_row(1, REG_OUTPUT_SELECT, SEL_NONE, 16'sh7FFF, 16'sh8000, 1, 16'sd0, 16'sd0, 0, 0);
		add_row(1, REG_OUTPUT_SELECT, SEL_BOTH, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0, 0);
		// Channel counts: one, zero treated as one, three saturating to two.
		add_row(1, REG_CHANNEL_COUNT, 16'd1, 16'sd3000, 16'sd3000, 0, 0, 0, 0, 0);
		add_row(1, REG_CHANNEL_COUNT, 16'd0, -16'sd3000, 16'sd3000, 0, 0, 0, 0, 0);
		add_row(1, REG_CHANNEL_COUNT, 16'd3, 16'sd7, -16'sd7, 0, 0, 0, 0, 0);
		add_row(1, REG_CHANNEL_COUNT, 16'd2, 16'sh5555, 16'shAAAA, 0, 0, 0, 0, 0);
		add_row(1, REG_ROOM_SIZE, 16'd0, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0, 0);
		add_row(1, REG_WET_MIX, 16'd32768, -16'sd1, 16'sd1, 0, 0, 0, 0, 0);
		add_row(1, REG_ROOM_SIZE, 16'd50000, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0, 0);

		foreach (rows[i]) begin
			if (rows[i].do_cfg) begin
				drain();
				write_register(rows[i].cfg_reg, rows[i].cfg_val);
				cfg_valid <= 1'b0;
			end
			if (rows[i].has_exp) begin
				// Typed-in values must agree with the predictor as well.
				send_sample(rows[i].l, rows[i].r);
				model_res = pending_results[$];
				if (model_res !== rows[i].exp) begin
					$error("directed row %0d: predictor %p, typed-in %p", i, model_res,
						rows[i].exp);
					fail_count++;
				end
			end else begin
				send_sample(rows[i].l, rows[i].r);
			end
		end

		// Random part in phases, each with a fresh setting. The long receiver
		// hold is triggered early so the sender runs into a full block.
		for (int k = 0; k < NUM_RANDOM; k++) begin
			if (k % 100 == 0) begin
				drain();
				for (int j = 0; j < 5; j++) begin
					ri = reg_index_t'(j);
					case (ri)
						REG_ROOM_SIZE, REG_WET_MIX:
							write_register(ri, ($urandom_range(0, 3) == 0)
								? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
								: 16'($urandom));
						default:
							// Mostly the ordinary settings, sometimes the odd codes.
							write_register(ri, ($urandom_range(0, 4) == 0)
								? 16'($urandom_range(0, 3))
								: ((ri == REG_CHANNEL_COUNT) ? 16'($urandom_range(1, 2))
								: 16'($urandom_range(0, 2))));
					endcase
				end
				cfg_valid <= 1'b0;
			end
			if (k == 150) hold_pending = 1'b1;
			// The sender pauses until everything outstanding has come back.
			if (k == 500) drain();
			if (k == NUM_RANDOM - 150) no_idle = 1'b1;
			send_sample(rand_sample(), rand_sample());
		end

		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
